// ----- rtl/core/ps2s1_pkg.sv -----
// shared types, constants and helper functions for the ps/2 set 1 decoder
// no dependencies; imported by the decode stage and the top level
`timescale 1ns / 1ps

package ps2s1_pkg;

   // event kinds
   localparam logic [2:0] KIND_NORMAL   = 3'd1;
   localparam logic [2:0] KIND_EXTENDED = 3'd2;
   localparam logic [2:0] KIND_PRTSC    = 3'd3;
   localparam logic [2:0] KIND_PAUSE    = 3'd4;

   localparam logic [7:0] BYTE_PREFIX = 8'hE0;
   localparam logic [7:0] BYTE_PAUSE  = 8'hE1;
   localparam logic [7:0] BYTE_PS_MK  = 8'h2A;
   localparam logic [7:0] BYTE_PS_BK  = 8'hB7;

   localparam logic [1:0] PRTSC_LAST  = 2'd3;
   localparam logic [2:0] PRTSC_START = 3'd2;
   localparam logic [2:0] PAUSE_LEN   = 3'd6;
   localparam logic [2:0] PAUSE_LAST  = 3'd5;

   localparam int MOD_W  = 11;
   localparam int CODE_W = 7;
   localparam int KEYS   = 128;

   // modifier key codes
   localparam logic [6:0] KEY_SHIFT_L = 7'h2A;
   localparam logic [6:0] KEY_SHIFT_R = 7'h36;
   localparam logic [6:0] KEY_CTRL    = 7'h1D;
   localparam logic [6:0] KEY_META_L  = 7'h5B;
   localparam logic [6:0] KEY_META_R  = 7'h5C;
   localparam logic [6:0] KEY_MENU    = 7'h5D;
   localparam logic [6:0] KEY_ALT     = 7'h38;
   localparam logic [6:0] KEY_CAPS    = 7'h3A;
   localparam logic [6:0] KEY_SCROLL  = 7'h46;

   typedef struct packed {
      logic       saw_prefix;
      logic       in_four_byte;
      logic       in_six_byte;
      logic [2:0] seq_pos;
   } port_state_type;

   typedef struct packed {
      logic              emit;
      logic [2:0]        kind;
      logic [CODE_W-1:0] code;
      logic              pressed;
      logic              first;
      logic              held_wr;
      logic              held_ext;
      logic              prtsc_wr;
   } decode_type;

   // print-screen make sequence e0 2a e0 37
   function automatic logic [7:0] prtsc_make_byte(input logic [1:0] idx);
      logic [7:0] b;
      case (idx)
         2'd0:    b = 8'hE0;
         2'd1:    b = 8'h2A;
         2'd2:    b = 8'hE0;
         default: b = 8'h37;
      endcase
      return b;
   endfunction

   // print-screen break sequence e0 b7 e0 aa
   function automatic logic [7:0] prtsc_break_byte(input logic [1:0] idx);
      logic [7:0] b;
      case (idx)
         2'd0:    b = 8'hE0;
         2'd1:    b = 8'hB7;
         2'd2:    b = 8'hE0;
         default: b = 8'hAA;
      endcase
      return b;
   endfunction

   // pause sequence e1 1d 45 e1 9d c5, only valid below PAUSE_LEN
   function automatic logic [7:0] pause_byte(input logic [2:0] idx);
      logic [7:0] b;
      case (idx)
         3'd0:    b = 8'hE1;
         3'd1:    b = 8'h1D;
         3'd2:    b = 8'h45;
         3'd3:    b = 8'hE1;
         3'd4:    b = 8'h9D;
         3'd5:    b = 8'hC5;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   function automatic logic [MOD_W-1:0] mod_snapshot(input logic [KEYS-1:0] nrm,
                                                      input logic [KEYS-1:0] ext);
      logic [MOD_W-1:0] m;
      m[0]  = nrm[KEY_SHIFT_L];
      m[1]  = nrm[KEY_SHIFT_R];
      m[2]  = nrm[KEY_CTRL];
      m[3]  = ext[KEY_CTRL];
      m[4]  = ext[KEY_META_L];
      m[5]  = ext[KEY_META_R];
      m[6]  = ext[KEY_MENU];
      m[7]  = nrm[KEY_ALT];
      m[8]  = ext[KEY_ALT];
      m[9]  = nrm[KEY_CAPS];
      m[10] = nrm[KEY_SCROLL];
      return m;
   endfunction

endpackage

// ----- rtl/core/ps2_set1_scancode_decoder.sv -----
// top level of the ps/2 scan code set 1 decoder: request register, shared
// key bitmaps, per-port sequence state and result register
// depends on ps2s1_pkg and ps2s1_decode
`timescale 1ns / 1ps

// usage
//  - the request channel carries one keyboard byte per request, with the
//    port it came on (1..PORT_COUNT) in req_tuser
//  - the response channel carries one key event: kind in rsp_tuser, make
//    code, press flag, new-press flag and an 11-bit modifier snapshot
//  - a request whose port is 0 or above PORT_COUNT is dropped with no
//    state change; prefix bytes and partial long sequences give no response
//  - response path: a taken request goes into the request register, then
//    is decoded into the response register, which drives rsp_tvalid
//  - throughput: one request per cycle unless the receiver stalls; decode
//    of a byte and the bitmap and sequence update all happen together, so
//    the next byte always sees the state the previous one left
//  - when the receiver stalls the response register holds its event and
//    the request register holds one byte; req_tready falls once both full
//  - reset (synchronous, active high) clears the key bitmaps, the
//    print-screen flag and every port's prefix and sequence state at once;
//    req_tready stays low during reset and requests are taken once it falls
module ps2_set1_scancode_decoder
   import ps2s1_pkg::*;
#(
   parameter int PORT_COUNT = 2
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] scan_byte
   input  logic [1:0]  req_tuser,   // [1:0] port
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [6:0] key_code, [7] pressed,
                                    // [8] new_press, [19:9] modifiers, rest 0
   output logic [2:0]  rsp_tuser    // [2:0] event_kind
);

   localparam int         PIDX_W   = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
   localparam logic [1:0] PORT_MAX = 2'(PORT_COUNT);

   // request register
   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_byte_ff,  s1_byte_in;
   logic [1:0] s1_port_ff,  s1_port_in;

   // shared key state
   logic [KEYS-1:0] normal_held_ff,   normal_held_in;
   logic [KEYS-1:0] extended_held_ff, extended_held_in;
   logic            prtsc_held_ff,    prtsc_held_in;

   // per-port prefix and sequence state
   port_state_type port_st_ff [PORT_COUNT];
   port_state_type port_st_in [PORT_COUNT];

   // response register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [2:0]        rsp_kind_ff,  rsp_kind_in;
   logic [CODE_W-1:0] rsp_code_ff,  rsp_code_in;
   logic              rsp_press_ff, rsp_press_in;
   logic              rsp_first_ff, rsp_first_in;
   logic [MOD_W-1:0]  rsp_mods_ff,  rsp_mods_in;

   logic              req_fire;
   logic              rsp_free;
   logic              s1_fire;
   logic              port_ok;
   logic              do_update;
   logic [PIDX_W-1:0] pidx;
   logic [CODE_W-1:0] key_idx;
   port_state_type    cur_st;
   port_state_type    nxt_st;
   decode_type        dec;
   logic [MOD_W-1:0]  mods_pre;
   logic [MOD_W-1:0]  mods_post;

   // handshake: the decode stage moves when the response register can take
   // its result, the request register refills in the same cycle
   assign rsp_free   = ~rsp_valid_ff | rsp_tready;
   assign s1_fire    = s1_valid_ff & rsp_free;
   assign req_tready = ~reset & (~s1_valid_ff | rsp_free);
   assign req_fire   = req_tvalid & req_tready;

   // port check and index
   assign port_ok   = (s1_port_ff != 2'd0) && (s1_port_ff <= PORT_MAX);
   assign pidx      = PIDX_W'(s1_port_ff - 2'd1);
   assign cur_st    = port_st_ff[pidx];
   assign key_idx   = s1_byte_ff[CODE_W-1:0];
   assign do_update = s1_fire & port_ok;

   ps2s1_decode u_decode (
      .scan_byte    (s1_byte_ff),
      .port_st      (cur_st),
      .normal_hit   (normal_held_ff[key_idx]),
      .extended_hit (extended_held_ff[key_idx]),
      .prtsc_held   (prtsc_held_ff),
      .port_st_next (nxt_st),
      .dec          (dec)
   );

   // state next values
   always_comb begin
      normal_held_in   = normal_held_ff;
      extended_held_in = extended_held_ff;
      prtsc_held_in    = prtsc_held_ff;
      for (int i = 0; i < PORT_COUNT; i++) begin
         port_st_in[i] = port_st_ff[i];
      end
      if (do_update) begin
         port_st_in[pidx] = nxt_st;
         if (dec.held_wr) begin
            if (dec.held_ext) begin
               extended_held_in[dec.code] = dec.pressed;
            end else begin
               normal_held_in[dec.code] = dec.pressed;
            end
         end
         if (dec.prtsc_wr) begin
            prtsc_held_in = dec.pressed;
         end
      end
   end

   // a press reports modifiers before its own update, a release after
   assign mods_pre  = mod_snapshot(normal_held_ff, extended_held_ff);
   assign mods_post = mod_snapshot(normal_held_in, extended_held_in);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_byte_in  = s1_byte_ff;
      s1_port_in  = s1_port_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
         s1_byte_in  = req_tdata;
         s1_port_in  = req_tuser;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_code_in  = rsp_code_ff;
      rsp_press_in = rsp_press_ff;
      rsp_first_in = rsp_first_ff;
      rsp_mods_in  = rsp_mods_ff;
      if (do_update && dec.emit) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = dec.kind;
         rsp_code_in  = dec.code;
         rsp_press_in = dec.pressed;
         rsp_first_in = dec.first;
         rsp_mods_in  = dec.pressed ? mods_pre : mods_post;
      end
   end

   // control and key state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         normal_held_ff   <= '0;
         extended_held_ff <= '0;
         prtsc_held_ff    <= 1'b0;
         for (int i = 0; i < PORT_COUNT; i++) begin
            port_st_ff[i] <= '0;
         end
      end else begin
         s1_valid_ff      <= s1_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
         normal_held_ff   <= normal_held_in;
         extended_held_ff <= extended_held_in;
         prtsc_held_ff    <= prtsc_held_in;
         for (int i = 0; i < PORT_COUNT; i++) begin
            port_st_ff[i] <= port_st_in[i];
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_byte_ff   <= s1_byte_in;
      s1_port_ff   <= s1_port_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_code_ff  <= rsp_code_in;
      rsp_press_ff <= rsp_press_in;
      rsp_first_ff <= rsp_first_in;
      rsp_mods_ff  <= rsp_mods_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {4'd0, rsp_mods_ff, rsp_first_ff, rsp_press_ff, rsp_code_ff};

endmodule

// ----- rtl/core/ps2s1_decode.sv -----
// per-byte decode of one port's prefix and long-sequence state
// depends on ps2s1_pkg; purely combinational
`timescale 1ns / 1ps

module ps2s1_decode
   import ps2s1_pkg::*;
(
   input  logic [7:0]     scan_byte,
   input  port_state_type port_st,
   input  logic           normal_hit,    // normal bitmap at scan_byte[6:0]
   input  logic           extended_hit,  // extended bitmap at scan_byte[6:0]
   input  logic           prtsc_held,
   output port_state_type port_st_next,
   output decode_type     dec
);

   logic       is_e0;
   logic [1:0] ps_idx;
   logic       ps_make;
   logic       ps_break;
   logic       plain;
   logic       ext_key;
   logic       press;

   assign is_e0    = (scan_byte == BYTE_PREFIX);
   assign ps_idx   = port_st.seq_pos[1:0];
   assign ps_make  = (scan_byte == prtsc_make_byte(ps_idx));
   assign ps_break = (scan_byte == prtsc_break_byte(ps_idx));
   assign press    = ~scan_byte[7];

   always_comb begin
      port_st_next = port_st;
      dec          = '0;
      dec.code     = scan_byte[CODE_W-1:0];
      plain        = 1'b0;
      ext_key      = port_st.saw_prefix;

      if (is_e0 && !port_st.in_four_byte && !port_st.in_six_byte) begin
         port_st_next.saw_prefix = 1'b1;
      end else if (port_st.saw_prefix && !port_st.in_four_byte &&
                   (scan_byte == BYTE_PS_MK || scan_byte == BYTE_PS_BK)) begin
         port_st_next.in_four_byte = 1'b1;
         port_st_next.seq_pos      = PRTSC_START;
         port_st_next.saw_prefix   = 1'b0;
      end else if (port_st.in_four_byte) begin
         port_st_next.saw_prefix = 1'b0;
         if (ps_make || ps_break) begin
            if (ps_idx == PRTSC_LAST) begin
               port_st_next.seq_pos      = '0;
               port_st_next.in_four_byte = 1'b0;
               dec.emit     = 1'b1;
               dec.kind     = KIND_PRTSC;
               dec.code     = '0;
               dec.pressed  = ps_make;
               dec.first    = ps_make & ~prtsc_held;
               dec.prtsc_wr = 1'b1;
            end else begin
               port_st_next.seq_pos = port_st.seq_pos + 3'd1;
            end
         end else begin
            port_st_next.seq_pos      = '0;
            port_st_next.in_four_byte = 1'b0;
         end
      end else if (scan_byte == BYTE_PAUSE) begin
         port_st_next.in_six_byte = 1'b1;
         port_st_next.seq_pos     = port_st.seq_pos + 3'd1;
         port_st_next.saw_prefix  = 1'b0;
      end else begin
         plain = 1'b1;
         if (port_st.in_six_byte) begin
            ext_key = 1'b0;
            if (port_st.seq_pos < PAUSE_LEN &&
                scan_byte == pause_byte(port_st.seq_pos)) begin
               plain = 1'b0;
               port_st_next.saw_prefix = 1'b0;
               if (port_st.seq_pos == PAUSE_LAST) begin
                  port_st_next.seq_pos     = '0;
                  port_st_next.in_six_byte = 1'b0;
                  dec.emit    = 1'b1;
                  dec.kind    = KIND_PAUSE;
                  dec.code    = '0;
                  dec.pressed = 1'b1;
                  dec.first   = 1'b1;
               end else begin
                  port_st_next.seq_pos = port_st.seq_pos + 3'd1;
               end
            end else begin
               port_st_next.seq_pos     = '0;
               port_st_next.in_six_byte = 1'b0;
            end
         end
         if (plain) begin
            dec.emit     = 1'b1;
            dec.kind     = ext_key ? KIND_EXTENDED : KIND_NORMAL;
            dec.pressed  = press;
            dec.first    = press & ~(ext_key ? extended_hit : normal_hit);
            dec.held_wr  = 1'b1;
            dec.held_ext = ext_key;
            port_st_next.saw_prefix = is_e0;
         end
      end
   end

endmodule
